>>> rtl/bmpc_pkg.sv
// Shared types and constants for the button multi-press classifier.
// No dependencies; used by bmpc_step and button_multi_press_classifier_core.
`default_nettype none

package bmpc_pkg;

    // Result event codes
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_LONG  = 2'd1,
        EV_MULTI = 2'd2
    } event_kind_t;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_INTERVAL = 1'b1;

    localparam int unsigned COUNT_W = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic [7:0]  DEBOUNCE_RST = 8'd50;
    localparam logic [31:0] INTERVAL_RST = 32'd500;

    // Classifier state carried from one request to the next
    typedef struct packed {
        logic               last_level;
        logic [31:0]        last_press_time;
        logic [COUNT_W-1:0] pending;
    } cls_state_t;

    // One result
    typedef struct packed {
        event_kind_t        kind;
        logic [COUNT_W-1:0] count;
    } cls_result_t;

endpackage

`default_nettype wire

>>> rtl/bmpc_step.sv
// Combinational next-state and result logic for one button sample.
// Depends on bmpc_pkg.
`default_nettype none

module bmpc_step (
    input  wire bmpc_pkg::cls_state_t  state,
    input  wire logic                  level,
    input  wire logic [31:0]           now_ms,
    input  wire logic [7:0]            debounce_ms,
    input  wire logic [31:0]           press_interval_ms,
    output bmpc_pkg::cls_state_t       state_next,
    output bmpc_pkg::cls_result_t      result
);

    logic [31:0] elapsed;
    logic        changed;
    logic        in_window;
    logic        past_interval;

    // Time since the last accepted press, modulo 2^32
    assign elapsed       = now_ms - state.last_press_time;
    assign changed       = (level != state.last_level);
    assign in_window     = (elapsed < {24'd0, debounce_ms});
    assign past_interval = (elapsed > press_interval_ms);

    always_comb
    begin
        state_next   = state;
        result.kind  = bmpc_pkg::EV_NONE;
        result.count = '0;
        if (changed && in_window)
        begin
            // bounce: ignore the change entirely
        end
        else if (changed && !level)
        begin
            // accepted press: restart the timer and count it
            state_next.last_level      = 1'b0;
            state_next.last_press_time = now_ms;
            if (state.pending != bmpc_pkg::COUNT_MAX)
            begin
                state_next.pending = state.pending + 1'b1;
            end
        end
        else if (changed && past_interval)
        begin
            // release after a long hold
            state_next.last_level = 1'b1;
            state_next.pending    = '0;
            result.kind           = bmpc_pkg::EV_LONG;
        end
        else if (level && (state.pending != '0) && past_interval)
        begin
            // released long enough: sequence is finished
            state_next.pending = '0;
            result.kind        = bmpc_pkg::EV_MULTI;
            result.count       = state.pending;
        end
        else
        begin
            state_next.last_level = level;
        end
    end

endmodule

`default_nettype wire

>>> rtl/button_multi_press_classifier_core.sv
// Top level of the button multi-press classifier: input register, state and result register.
// Depends on bmpc_pkg and bmpc_step.
`default_nettype none

// Classifies button samples into long presses and finished multi-press
// sequences. Each request (level, now_ms) yields exactly one result (event_kind,
// press_count). A request is taken into an input register, evaluated combinationally
// against the stored state and written to the result register, so the block
// sustains one request per clock while the result channel is not stalled; the result register
// and the input register let a new request enter while a result waits to be taken.
// Configuration writes (index 0 debounce_ms, index 1 press_interval_ms) take
// effect on the next clock and belong in idle periods.
module button_multi_press_classifier_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        level,
    input  wire logic [31:0] now_ms,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       event_kind,
    output logic [6:0]       press_count
);

    logic [7:0]             debounce_ms_reg;
    logic [31:0]            press_interval_ms_reg;
    logic                   in_vld_reg;
    logic                   level_reg;
    logic [31:0]            now_ms_reg;
    bmpc_pkg::cls_state_t   state_reg;
    bmpc_pkg::cls_state_t   state_next;
    bmpc_pkg::cls_result_t  step_result;
    bmpc_pkg::cls_result_t  out_reg;
    logic                   out_vld_reg;
    logic                   out_free;
    logic                   advance;
    logic                   in_take;

    // Handshake control
    assign out_free = !out_vld_reg || !out_stall;
    assign advance  = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg       <= bmpc_pkg::DEBOUNCE_RST;
            press_interval_ms_reg <= bmpc_pkg::INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bmpc_pkg::CFG_DEBOUNCE: debounce_ms_reg       <= cfg_data[7:0];
                bmpc_pkg::CFG_INTERVAL: press_interval_ms_reg <= cfg_data;
                default:                debounce_ms_reg       <= debounce_ms_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (out_free || !in_vld_reg)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            level_reg  <= level;
            now_ms_reg <= now_ms;
        end
    end

    // Step logic
    bmpc_step u_step (
        .state             (state_reg),
        .level             (level_reg),
        .now_ms            (now_ms_reg),
        .debounce_ms       (debounce_ms_reg),
        .press_interval_ms (press_interval_ms_reg),
        .state_next        (state_next),
        .result            (step_result)
    );

    // Classifier state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.last_level      <= 1'b1;
            state_reg.last_press_time <= '0;
            state_reg.pending         <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid   = out_vld_reg;
    assign event_kind  = out_reg.kind;
    assign press_count = out_reg.count;

`ifndef NO_ASSERTIONS
    // Only a finished sequence carries a count
    a_count_only_multi: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_reg.kind != bmpc_pkg::EV_MULTI)) |-> (out_reg.count == '0))
        else $error("press_count nonzero on a non-sequence result");

    // A long press clears the pending count
    a_long_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (step_result.kind == bmpc_pkg::EV_LONG)) |=> (state_reg.pending == '0))
        else $error("pending count kept after long press");

    // A finished sequence clears the count and the button stays released
    a_multi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (step_result.kind == bmpc_pkg::EV_MULTI))
            |=> ((state_reg.pending == '0) && state_reg.last_level))
        else $error("bad state after sequence report");

    // State only moves when a request is evaluated
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a request");
`endif

endmodule

`default_nettype wire

>>> tb/button_multi_press_classifier_core_test.sv
// Self-checking testbench for button_multi_press_classifier_core: directed and random
// button samples under several debounce/interval settings, checked against a local model.
// Depends on bmpc_pkg and the classifier RTL only.
`default_nettype none

module button_multi_press_classifier_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected-event store with its own copy of the classifier state and registers
    class press_event_board;
        logic [7:0]                   debounce;
        logic [31:0]                  interval;
        logic                         last_level;
        logic [31:0]                  press_time;
        logic [bmpc_pkg::COUNT_W-1:0] pending;
        bmpc_pkg::cls_result_t        expected_events[$];
        int unsigned                  mismatches;
        int unsigned                  checked;
        int unsigned                  longs_seen;
        int unsigned                  multis_seen;
        int unsigned                  saturated_seen;
        int unsigned                  ignored_edges;

        function new();
            debounce       = bmpc_pkg::DEBOUNCE_RST;
            interval       = bmpc_pkg::INTERVAL_RST;
            last_level     = 1'b1;
            press_time     = '0;
            pending        = '0;
            mismatches     = 0;
            checked        = 0;
            longs_seen     = 0;
            multis_seen    = 0;
            saturated_seen = 0;
            ignored_edges  = 0;
        endfunction

        function void write_reg(input logic idx, input logic [31:0] data);
            if (idx == bmpc_pkg::CFG_DEBOUNCE)
                debounce = data[7:0];
            else
                interval = data;
        endfunction

        function int unsigned outstanding();
            return expected_events.size();
        endfunction

        // Work out the event caused by one accepted request
        function void note_request(input logic lvl, input logic [31:0] stamp_ms);
            logic [31:0] elapsed;
            bmpc_pkg::cls_result_t ev;
            elapsed  = stamp_ms - press_time;
            ev.kind  = bmpc_pkg::EV_NONE;
            ev.count = '0;
            if (lvl != last_level && elapsed < {24'd0, debounce}) begin
                // level change inside the debounce window: state untouched
                ignored_edges++;
                expected_events.push_back(ev);
                return;
            end
            if (lvl != last_level) begin
                if (lvl == 1'b0) begin
                    press_time = stamp_ms;
                    elapsed    = '0;
                    if (pending != bmpc_pkg::COUNT_MAX)
                        pending = pending + 1'b1;
                end else if (elapsed > interval) begin
                    // long press: count dropped, no sequence report
                    last_level = lvl;
                    pending    = '0;
                    ev.kind    = bmpc_pkg::EV_LONG;
                    expected_events.push_back(ev);
                    return;
                end
            end
            if (pending != 0 && lvl == 1'b1 && elapsed > interval) begin
                // sequence finished; last_level stays as it was
                ev.kind  = bmpc_pkg::EV_MULTI;
                ev.count = pending;
                pending  = '0;
                expected_events.push_back(ev);
                return;
            end
            last_level = lvl;
            expected_events.push_back(ev);
        endfunction

        // Compare one accepted result with the oldest expected event
        function void check_event(input logic [1:0] kind, input logic [6:0] count);
            bmpc_pkg::cls_result_t ev;
            if (expected_events.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: kind %0d count %0d", kind, count);
                mismatches++;
                return;
            end
            ev = expected_events.pop_front();
            checked++;
            if (kind !== ev.kind || count !== ev.count) begin
                if (mismatches < 10)
                    $display("mismatch at result %0d: kind exp %0d got %0d, count exp %0d got %0d",
                             checked, ev.kind, kind, ev.count, count);
                mismatches++;
            end
            if (ev.kind == bmpc_pkg::EV_LONG)
                longs_seen++;
            if (ev.kind == bmpc_pkg::EV_MULTI)
                multis_seen++;
            if (ev.kind == bmpc_pkg::EV_MULTI && ev.count == bmpc_pkg::COUNT_MAX)
                saturated_seen++;
        endfunction
    endclass

    localparam int NUM_PHASES = 8;
    localparam int BURST_PHASE = 3;
    localparam int unsigned DEB_SET [NUM_PHASES] = '{50, 0, 255, 4, 10, 1, 255, 20};
    localparam int unsigned INTV_SET [NUM_PHASES] =
        '{500, 0, 32'hFFFF_FFFF, 300, 60, 2, 256, 1000};

    // Opening requests under reset settings: {level, now_ms}
    localparam logic [32:0] OPENING [24] = '{
        {1'b1, 32'h0000_0000}, {1'b0, 32'd49},         {1'b0, 32'd50},
        {1'b1, 32'd99},        {1'b1, 32'd100},        {1'b1, 32'd550},
        {1'b1, 32'd551},       {1'b0, 32'd600},        {1'b0, 32'd1100},
        {1'b1, 32'd1100},      {1'b0, 32'd1101},       {1'b1, 32'd1602},
        {1'b1, 32'd2000},      {1'b0, 32'hFFFF_FFF0},  {1'b1, 32'h0000_0021},
        {1'b1, 32'h0000_0022}, {1'b0, 32'h0000_0060},  {1'b1, 32'h0000_00A0},
        {1'b1, 32'h0000_0254}, {1'b1, 32'h0000_0255},  {1'b0, 32'hFFFF_FFFF},
        {1'b1, 32'hFFFF_FFFF}, {1'b0, 32'h7FFF_FFFF},  {1'b1, 32'h8000_0000}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_index   = bmpc_pkg::CFG_DEBOUNCE;
    logic [31:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        level       = 1'b1;
    logic [31:0] now_ms      = '0;
    logic        out_stall   = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  event_kind;
    logic [6:0]  press_count;

    press_event_board board = new();
    logic [31:0]  stamp       = '0;
    int unsigned  sent_count  = 0;
    bit           rush        = 1'b0;
    int unsigned  stall_hold  = 0;
    int unsigned  stall_pick;

    button_multi_press_classifier_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .level       (level),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .press_count (press_count)
    );

    always #5 clk = ~clk;

    // Hard limit on run time
    initial
    begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Watch both handshakes
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                board.note_request(level, now_ms);
            if (out_valid && !out_stall)
                board.check_event(event_kind, press_count);
        end
    end

    // Result-side back-pressure: short and long stalls, with free stretches
    always @(posedge clk)
    begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 55) begin
                out_stall  <= 1'b0;
                stall_hold <= $urandom_range(0, 6);
            end else if (stall_pick < 62) begin
                out_stall  <= 1'b0;
                stall_hold <= $urandom_range(40, 120);
            end else if (stall_pick < 92) begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(0, 2);
            end else begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(8, 30);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (rush || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offset that lands on, just under or just past a timing threshold
    function automatic logic [31:0] around(input logic [31:0] mark);
        case ($urandom_range(0, 5))
            0:       return mark - 1;
            1:       return mark;
            2:       return mark + 1;
            default: return mark + $urandom_range(0, 15);
        endcase
    endfunction

    // Keeps random hold and gap times short when the interval is large
    function automatic int unsigned span(input int unsigned intv);
        return (intv > 200) ? 200 : intv;
    endfunction

    task automatic send_req(input logic lvl, input logic [31:0] t);
        int unsigned gap;
        in_valid <= 1'b1;
        level    <= lvl;
        now_ms   <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        stamp = t;
        sent_count++;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off requests until every expected event has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        // first let the monitor note the last accepted request
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] deb, input logic [31:0] intv);
        cfg_we    <= 1'b1;
        cfg_index <= bmpc_pkg::CFG_DEBOUNCE;
        cfg_data  <= {24'd0, deb};
        @(posedge clk);
        board.write_reg(bmpc_pkg::CFG_DEBOUNCE, {24'd0, deb});
        cfg_index <= bmpc_pkg::CFG_INTERVAL;
        cfg_data  <= intv;
        @(posedge clk);
        board.write_reg(bmpc_pkg::CFG_INTERVAL, intv);
        cfg_we <= 1'b0;
    endtask

    // Several quick presses, optional contact bounce, then wait out the interval
    task automatic run_clicks(input int unsigned deb, input int unsigned intv);
        int unsigned n;
        logic [31:0] t;
        logic [31:0] pressed;
        n = $urandom_range(1, 6);
        t = stamp + 1 + $urandom_range(0, deb);
        pressed = t;
        for (int i = 0; i < n; i++) begin
            pressed = t;
            send_req(1'b0, t);
            if ($urandom_range(0, 3) == 0)
                send_req(1'b1, t + $urandom_range(0, deb));
            t = t + around(deb) + $urandom_range(0, span(intv) / 2);
            send_req(1'b1, t);
            t = t + around(deb) + $urandom_range(0, span(intv) / 2);
        end
        send_req(1'b1, pressed + around(intv));
        send_req(1'b1, pressed + intv + 1 + $urandom_range(0, 20));
    endtask

    // One press held near or past the interval
    task automatic run_hold(input int unsigned deb, input int unsigned intv);
        logic [31:0] t;
        t = stamp + 1 + $urandom_range(0, deb);
        send_req(1'b0, t);
        repeat ($urandom_range(0, 3))
            send_req(1'b0, t + $urandom_range(0, span(intv)));
        send_req(1'b1, t + around(intv));
        send_req(1'b1, t + intv + 1 + $urandom_range(0, 20));
    endtask

    // Random levels and times, now and then a jump anywhere on the clock
    task automatic run_noise(input int unsigned deb, input int unsigned intv);
        logic [31:0] t;
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 7) == 0)
                t = $urandom;
            else
                t = stamp + $urandom_range(0, 2 * span(intv) + deb);
            send_req(1'($urandom_range(0, 1)), t);
        end
    endtask

    // Enough presses inside one sequence to saturate the count
    task automatic run_burst(input int unsigned deb, input int unsigned intv);
        logic [31:0] t;
        logic [31:0] pressed;
        t = stamp + intv + deb + 1;
        pressed = t;
        for (int i = 0; i < 130; i++) begin
            pressed = t;
            send_req(1'b0, t);
            send_req(1'b1, t + deb);
            t = t + 2 * deb;
        end
        send_req(1'b1, pressed + intv + 1);
    endtask

    // Main stimulus: reset, opening requests, then random phases per setting
    initial
    begin
        int unsigned deb;
        int unsigned intv;
        int unsigned pick;
        int unsigned start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            deb  = DEB_SET[p];
            intv = INTV_SET[p];
            if (p != 0) begin
                wait_idle();
                set_config(deb[7:0], intv);
            end
            if (p == 0) begin
                for (int i = 0; i < 24; i++)
                    send_req(OPENING[i][32], OPENING[i][31:0]);
            end
            if (p == BURST_PHASE)
                run_burst(deb, intv);
            start = sent_count;
            while (sent_count - start < 100) begin
                rush = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    run_clicks(deb, intv);
                end else if (pick < 72) begin
                    run_hold(deb, intv);
                end else if (pick < 86) begin
                    run_noise(deb, intv);
                end else if (pick < 94) begin
                    // sequence across the timestamp wrap
                    stamp = 32'hFFFF_FFFF - $urandom_range(0, 3 * span(intv) + deb);
                    run_clicks(deb, intv);
                end else if (pick < 97) begin
                    wait_idle();
                end else begin
                    stamp = $urandom;
                    run_hold(deb, intv);
                end
            end
        end
        wait_idle();
        repeat (10) @(posedge clk);
        $display("Sent %0d requests over %0d register settings, %0d results checked.",
                 sent_count, NUM_PHASES, board.checked);
        $display("Seen %0d long presses, %0d finished sequences (%0d saturated), %0d bounces.",
                 board.longs_seen, board.multis_seen, board.saturated_seen,
                 board.ignored_edges);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
